FILE: rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// Used by every module in this folder; no dependencies of its own.
`timescale 1ns / 1ps

package spq_pkg;

    localparam logic [1:0] MAX_PRIO = 2'd3;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] prio;
        logic [7:0] data;
    } t_entry;

    // Broadcast to every cell in the chain for the request being executed.
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

FILE: rtl/spq_cell.sv
// One storage cell of the sorted queue chain.
// Depends on spq_pkg for the entry and control types.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_valid,
    input  logic                  i_prev_moves,
    input  spq_pkg::t_entry       i_left,
    input  spq_pkg::t_entry       i_right,
    output logic                  o_moves,
    output spq_pkg::t_entry       o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // A cell moves on insert when it is empty or holds a strictly larger
    // priority; the sorted order keeps these cells as a suffix of the chain.
    assign o_moves = !(i_valid && (r_entry.prio <= i_ctl.new_entry.prio));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (o_moves && i_prev_moves) begin
                n_entry = i_left;
            end else if (o_moves) begin
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: rtl/stable_priority_queue.sv
// Stable priority queue: a chain of cells kept sorted by priority, FIFO within a priority.
// Each accepted request gives one result the next cycle; one per cycle unless results stall.
// All cells compare against the new item in parallel and shift by one place.
// Reset (i_rst_n low, synchronous) empties the queue and clears the result valid flag.
// Cell contents are not cleared; only entries below the fill count are ever read.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps

module stable_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] item_data, [10:8] item_priority, [15:11] zero
    input  logic        i_s_tuser,   // [0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_data, [9:8] out_priority, [14:10] fill_count
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [15:0]          r_out_data;
    logic [15:0]          n_out_data;
    spq_pkg::t_status     r_out_status;
    spq_pkg::t_status     n_out_status;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic [1:0]           w_prio;
    spq_pkg::t_cmd        w_cmd;
    spq_pkg::t_cell_ctl   w_ctl;
    spq_pkg::t_entry      w_entry [CAPACITY];
    logic [CAPACITY-1:0]  w_moves;
    logic [CAPACITY-1:0]  w_valid;
    logic [31:0]          w_cnt32;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_cmd      = spq_pkg::t_cmd'(i_s_tuser);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_prio     = (i_s_tdata[10:8] > 3'(spq_pkg::MAX_PRIO)) ? spq_pkg::MAX_PRIO
                                                                : i_s_tdata[9:8];

    assign w_ctl.enq            = w_accept && (w_cmd == spq_pkg::CMD_ENQ) && !w_full;
    assign w_ctl.deq            = w_accept && (w_cmd == spq_pkg::CMD_DEQ) && !w_empty;
    assign w_ctl.new_entry.prio = w_prio;
    assign w_ctl.new_entry.data = i_s_tdata[7:0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g] = (r_count > CW'(g));

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (w_valid[g]),
            .i_prev_moves ((g == 0) ? 1'b0 : w_moves[(g == 0) ? 0 : g - 1]),
            .i_left       (w_entry[(g == 0) ? 0 : g - 1]),
            .i_right      (w_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .o_moves      (w_moves[g]),
            .o_entry      (w_entry[g])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        w_cnt32      = 32'(r_count);
        if (w_ctl.enq) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.deq) begin
            n_count = r_count - CW'(1);
        end
        w_cnt32 = 32'(n_count);
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_data  = {1'b0, w_cnt32[4:0], 10'd0};
            unique case (w_cmd)
                spq_pkg::CMD_ENQ: begin
                    n_out_status = w_full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
                end
                spq_pkg::CMD_DEQ: begin
                    if (w_empty) begin
                        n_out_status = spq_pkg::ST_EMPTY;
                    end else begin
                        n_out_status     = spq_pkg::ST_DONE;
                        n_out_data[9:0]  = w_entry[0];
                    end
                end
                default: begin
                    n_out_status = spq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_entry[0].prio <= w_entry[1].prio))
        else $error("queue head is out of priority order");

    a_deq_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.deq |=> (r_count == $past(r_count) - CW'(1)))
        else $error("dequeue did not shrink the queue by one");

    a_enq_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == spq_pkg::CMD_ENQ) && w_full) |=>
            ($stable(r_count) && (o_m_tuser == spq_pkg::ST_FULL)))
        else $error("enqueue on full queue was not dropped");

endmodule

FILE: bench/tb_stable_priority_queue.sv
// Self-checking testbench for the stable priority queue.
// Drives enqueue and dequeue requests and checks every result; needs spq_pkg
// and the stable_priority_queue RTL.
`timescale 1ns / 1ps

module tb_stable_priority_queue;

    localparam int QUEUE_DEPTH    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;

    typedef struct {
        logic [7:0]       data;
        logic [1:0]       prio;
        spq_pkg::t_status status;
        logic [4:0]       fill;
    } t_queue_result;

    // Keeps its own sorted copy of the queue and the results still owed.
    class queue_tracker;
        spq_pkg::t_entry held_entries [QUEUE_DEPTH];
        int unsigned     held_count;
        t_queue_result   awaited_results [$];
        int unsigned     failures;

        function new();
            held_count = 0;
            failures   = 0;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function void note_request(spq_pkg::t_cmd cmd, logic [7:0] data, logic [2:0] prio_in);
            spq_pkg::t_entry fresh;
            t_queue_result   r;
            int              pos;
            fresh.data = data;
            fresh.prio = (prio_in > 3'(spq_pkg::MAX_PRIO)) ? spq_pkg::MAX_PRIO : prio_in[1:0];
            r.data   = '0;
            r.prio   = '0;
            r.status = spq_pkg::ST_DONE;
            if (cmd == spq_pkg::CMD_ENQ) begin
                if (held_count >= QUEUE_DEPTH) begin
                    r.status = spq_pkg::ST_FULL;
                end else begin
                    // A new entry goes behind everything of equal or higher urgency.
                    pos = 0;
                    while (pos < held_count && held_entries[pos].prio <= fresh.prio)
                        pos++;
                    for (int k = held_count; k > pos; k--)
                        held_entries[k] = held_entries[k - 1];
                    held_entries[pos] = fresh;
                    held_count++;
                end
            end else begin
                if (held_count == 0) begin
                    r.status = spq_pkg::ST_EMPTY;
                end else begin
                    r.data = held_entries[0].data;
                    r.prio = held_entries[0].prio;
                    for (int k = 1; k < held_count; k++)
                        held_entries[k - 1] = held_entries[k];
                    held_count--;
                end
            end
            r.fill = held_count[4:0];
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [15:0] tdata, logic [1:0] tuser);
            t_queue_result want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: tdata %h tuser %0d", tdata, tuser);
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            if (tdata[7:0] !== want.data) begin
                $error("out_data: expected %0d, got %0d", want.data, tdata[7:0]);
                failures++;
            end
            if (tdata[9:8] !== want.prio) begin
                $error("out_priority: expected %0d, got %0d", want.prio, tdata[9:8]);
                failures++;
            end
            if (tuser !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, tuser);
                failures++;
            end
            if (tdata[14:10] !== want.fill) begin
                $error("fill_count: expected %0d, got %0d", want.fill, tdata[14:10]);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [7:0] item_data, [10:8] item_priority, [15:11] zero
    logic        i_s_tuser  = 1'b0; // [0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [7:0] out_data, [9:8] out_priority, [14:10] fill_count
    logic [1:0]  o_m_tuser;         // [1:0] status

    bit          calm_tail     = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned idle_cycles   = 0;

    queue_tracker tracker = new();

    stable_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Handshakes are sampled right after the edge, so they see pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                tracker.note_request(spq_pkg::t_cmd'(i_s_tuser), i_s_tdata[7:0],
                                     i_s_tdata[10:8]);
            if (o_m_tvalid && i_m_tready)
                tracker.check_result(o_m_tdata, o_m_tuser);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("stable_priority_queue regression: fail");
                $finish;
            end
        end
    end

    // Result side: random stalls, one long hold-off on request, none at the tail.
    initial begin
        wait (i_rst_n);
        forever begin
            if (long_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(spq_pkg::t_cmd cmd, logic [7:0] data, logic [2:0] prio);
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, prio, data};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // Enqueue share is redrawn every 20 requests so the queue swings between empty and full.
    task automatic random_requests(int count);
        int            enq_pct;
        spq_pkg::t_cmd cmd;
        enq_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 25;
                    1: enq_pct = 50;
                    default: enq_pct = 80;
                endcase
            end
            cmd = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
            send_request(cmd, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        logic [2:0] fill_prios [16];
        fill_prios = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd2, 3'd0, 3'd4, 3'd1,
                       3'd3, 3'd0, 3'd5, 3'd2, 3'd6, 3'd1, 3'd0, 3'd3};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Dequeue from the empty queue, fill it with mixed priorities,
        // then overflow it and take a few entries back out.
        send_request(spq_pkg::CMD_DEQ, 8'hFF, 3'd7);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(spq_pkg::CMD_ENQ, 8'(i * 17), fill_prios[i]);
        send_request(spq_pkg::CMD_ENQ, 8'hA5, 3'd0);
        repeat (4) send_request(spq_pkg::CMD_DEQ, 8'h00, 3'd0);
        // Equal priorities must leave in arrival order.
        send_request(spq_pkg::CMD_ENQ, 8'h11, 3'd2);
        send_request(spq_pkg::CMD_ENQ, 8'h22, 3'd2);
        send_request(spq_pkg::CMD_ENQ, 8'h33, 3'd2);
        drain_results();

        random_requests(150);
        long_hold_req = 1'b1;
        random_requests(40);
        drain_results();
        random_requests(130);
        calm_tail = 1'b1;
        random_requests(80);
        drain_results();
        repeat (10) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("stable_priority_queue regression: pass");
        else
            $display("stable_priority_queue regression: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
bench/tb_stable_priority_queue.sv
